@@ hdl/sws_pkg.sv @@
// Package for the signed word sorter: capacity, widths and the controller state type.
// No dependencies.
`default_nettype none
package sws_pkg;
    localparam int Capacity = 64;
    localparam int AddrW = $clog2(Capacity);
    localparam int CountW = $clog2(Capacity + 1);
    localparam int DataW = 64;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SEL_READ,
        ST_SEL_SCAN,
        ST_SEL_SWAP,
        ST_SEL_PLACE,
        ST_EMIT
    } sws_state_t;

    function automatic logic signed_less(input logic [DataW-1:0] a, input logic [DataW-1:0] b);
        signed_less = $signed(a) < $signed(b);
    endfunction
endpackage
`default_nettype wire

@@ hdl/signed_word_sorter.sv @@
// Top level of the signed word sorter: loads a set into a RAM, sorts it in place by
// selection over one synchronous read port, then streams it out. Uses sws_pkg.
//
// Channel   Dir  Payload
// s_axis    in   tdata[63:0] value, tlast final_item
// m_axis    out  tdata[63:0] sorted_value, tlast final_result, tuser overflowed
//
// Loading accepts one transaction per cycle. The sort is a selection pass per position,
// its pace set by the single RAM read and write port. During emission each element is
// read from the RAM and moved into the output register before the next read is issued.
// Input is not accepted during sort and emission. rst_n clears the count and state.
`default_nettype none
module signed_word_sorter (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [sws_pkg::DataW-1:0] s_axis_tdata,  // value
    input  wire logic                      s_axis_tlast,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    output logic [sws_pkg::DataW-1:0]      m_axis_tdata,  // sorted_value
    output logic                           m_axis_tlast,
    output logic                           m_axis_tuser,  // overflowed
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready
);
    import sws_pkg::*;

    logic [DataW-1:0] mem [Capacity];
    logic [DataW-1:0] rd_data_reg;
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [DataW-1:0] wr_data;

    sws_state_t state_reg, state_next;
    logic [CountW-1:0] count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [CountW-1:0] pos_reg, pos_next;
    logic [CountW-1:0] scan_reg, scan_next;
    logic [AddrW-1:0]  min_idx_reg, min_idx_next;
    logic [DataW-1:0]  min_val_reg, min_val_next;
    logic [DataW-1:0]  head_val_reg, head_val_next;
    logic              first_reg, first_next;
    logic              pend_reg, pend_next;
    logic [DataW-1:0]  out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;
    logic              out_ovf_reg, out_ovf_next;
    logic              out_valid_reg, out_valid_next;
    logic              in_acc;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign in_acc = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc && s_axis_tlast)
                begin
                    state_next = ST_SEL_READ;
                end
            end
            ST_SEL_READ:
            begin
                if (pos_reg + CountW'(1) >= count_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SEL_SCAN;
                end
            end
            ST_SEL_SCAN:
            begin
                if (!first_reg && scan_reg >= count_reg)
                begin
                    state_next = ST_SEL_SWAP;
                end
            end
            ST_SEL_SWAP:
            begin
                state_next = ST_SEL_PLACE;
            end
            ST_SEL_PLACE:
            begin
                state_next = ST_SEL_READ;
            end
            ST_EMIT:
            begin
                if (pos_reg >= count_reg && !pend_reg
                    && !(out_valid_reg && !m_axis_tready))
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        ovf_next = ovf_reg;
        pos_next = pos_reg;
        scan_next = scan_reg;
        min_idx_next = min_idx_reg;
        min_val_next = min_val_reg;
        head_val_next = head_val_reg;
        first_next = first_reg;
        pend_next = pend_reg;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        out_ovf_next = out_ovf_reg;
        out_valid_next = out_valid_reg;
        rd_addr = pos_reg[AddrW-1:0];
        wr_en = 1'b0;
        wr_addr = count_reg[AddrW-1:0];
        wr_data = s_axis_tdata;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (count_reg < CountW'(Capacity))
                    begin
                        wr_en = 1'b1;
                        count_next = count_reg + CountW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    pos_next = '0;
                end
            end
            ST_SEL_READ:
            begin
                rd_addr = pos_reg[AddrW-1:0];
                scan_next = pos_reg + CountW'(1);
                first_next = 1'b1;
                if (pos_reg + CountW'(1) >= count_reg)
                begin
                    pos_next = '0;
                    pend_next = 1'b0;
                end
            end
            ST_SEL_SCAN:
            begin
                rd_addr = scan_reg[AddrW-1:0];
                if (first_reg)
                begin
                    head_val_next = rd_data_reg;
                    min_val_next = rd_data_reg;
                    min_idx_next = pos_reg[AddrW-1:0];
                    first_next = 1'b0;
                end
                else
                begin
                    if (signed_less(rd_data_reg, min_val_reg))
                    begin
                        min_val_next = rd_data_reg;
                        min_idx_next = AddrW'(scan_reg - CountW'(1));
                    end
                end
                if (!first_reg || scan_reg < count_reg)
                begin
                    if (scan_reg < count_reg)
                    begin
                        scan_next = scan_reg + CountW'(1);
                    end
                end
            end
            ST_SEL_SWAP:
            begin
                wr_en = 1'b1;
                wr_addr = min_idx_reg;
                wr_data = head_val_reg;
            end
            ST_SEL_PLACE:
            begin
                wr_en = 1'b1;
                wr_addr = pos_reg[AddrW-1:0];
                wr_data = min_val_reg;
                pos_next = pos_reg + CountW'(1);
            end
            ST_EMIT:
            begin
                if (pend_reg)
                begin
                    rd_addr = AddrW'(pos_reg - CountW'(1));
                end
                if (pend_reg && (!out_valid_reg || m_axis_tready))
                begin
                    out_data_next = rd_data_reg;
                    out_last_next = (pos_reg >= count_reg);
                    out_ovf_next = ovf_reg;
                    out_valid_next = 1'b1;
                    pend_next = 1'b0;
                end
                else if (!pend_reg && pos_reg < count_reg)
                begin
                    rd_addr = pos_reg[AddrW-1:0];
                    pos_next = pos_reg + CountW'(1);
                    pend_next = 1'b1;
                end
                if (pos_reg >= count_reg && !pend_reg && !(out_valid_reg && !m_axis_tready))
                begin
                    count_next = '0;
                    ovf_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg <= 1'b0;
            pos_reg <= '0;
            pend_reg <= 1'b0;
            first_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg <= ovf_next;
            pos_reg <= pos_next;
            pend_reg <= pend_next;
            first_reg <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        min_idx_reg <= min_idx_next;
        min_val_reg <= min_val_next;
        head_val_reg <= head_val_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign m_axis_tdata = out_data_reg;
    assign m_axis_tlast = out_last_reg;
    assign m_axis_tuser = out_ovf_reg;
    assign m_axis_tvalid = out_valid_reg;

    a_ready_only_load: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> state_reg == ST_LOAD) else $error("ready outside load");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountW'(Capacity)) else $error("count overrun");
    a_no_out_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && $past(state_reg) == ST_LOAD) |-> !m_axis_tvalid)
        else $error("output during load");
endmodule
`default_nettype wire

@@ dv/signed_word_sorter_tb.sv @@
// Testbench for the signed word sorter: drives sets of signed words, predicts the sorted
// output with its own sort, and checks each output transaction. Depends on sws_pkg.
module signed_word_sorter_tb;
    import sws_pkg::*;

    typedef struct packed {
        logic [DataW-1:0] value;
        logic             last;
    } load_t;

    typedef struct packed {
        logic [DataW-1:0] value;
        logic             last;
        logic             ovf;
    } sorted_t;

    logic             clk;
    logic             rst_n;
    logic [DataW-1:0] s_axis_tdata;
    logic             s_axis_tlast;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [DataW-1:0] m_axis_tdata;
    logic             m_axis_tlast;
    logic             m_axis_tuser;
    logic             m_axis_tvalid;
    logic             m_axis_tready;

    logic [DataW-1:0] held_words[$];
    logic             held_ovf;
    sorted_t          pending_sorted[$];
    int               mismatches;
    bit               idle_enable;
    load_t            directed_rows[$];
    sorted_t          directed_sorted[$];

    localparam logic [DataW-1:0] MinWord = 64'h8000_0000_0000_0000;
    localparam logic [DataW-1:0] MaxWord = 64'h7fff_ffff_ffff_ffff;

    signed_word_sorter dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Updates the held set on an accepted transaction and queues the sorted set on the last.
    task automatic predict_sorted(input load_t item);
        logic [DataW-1:0] word;
        int               pos;
        sorted_t          res;
        if (held_words.size() < Capacity)
            held_words.push_back(item.value);
        else
            held_ovf = 1'b1;
        if (item.last)
        begin
            for (int i = 1; i < held_words.size(); i++)
            begin
                word = held_words[i];
                pos = i;
                while (pos > 0 && $signed(word) < $signed(held_words[pos-1]))
                begin
                    held_words[pos] = held_words[pos-1];
                    pos--;
                end
                held_words[pos] = word;
            end
            foreach (held_words[k])
            begin
                res.value = held_words[k];
                res.last = (k == held_words.size() - 1);
                res.ovf = held_ovf;
                pending_sorted.push_back(res);
            end
            held_words.delete();
            held_ovf = 1'b0;
        end
    endtask

    task automatic report_mismatch(input sorted_t exp_r, input sorted_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: expected value %h last %b ovf %b, got value %h last %b ovf %b",
                     exp_r.value, exp_r.last, exp_r.ovf, got.value, got.last, got.ovf);
    endtask

    task automatic send_item(input load_t item);
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_axis_tdata <= item.value;
        s_axis_tlast <= item.last;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_sorted(item);
    endtask

    task automatic drain_wait();
        s_axis_tvalid <= 1'b0;
        while (pending_sorted.size() != 0) @(posedge clk);
    endtask

    function automatic logic [DataW-1:0] random_word();
        logic [DataW-1:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: w = MinWord;
            1: w = MaxWord;
            2: w = DataW'($signed($urandom_range(0, 3)) - 2);
            3: w = DataW'($urandom_range(0, 7));
            default: ;
        endcase
        return w;
    endfunction

    function automatic load_t row(input logic [DataW-1:0] v, input logic l);
        load_t r;
        r.value = v;
        r.last = l;
        return r;
    endfunction

    // Receiver: random stalls, checks each transaction against the oldest expectation.
    always @(posedge clk)
    begin
        sorted_t got;
        sorted_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.value = m_axis_tdata;
            got.last = m_axis_tlast;
            got.ovf = m_axis_tuser;
            if (pending_sorted.size() == 0)
            begin
                exp_r = '0;
                report_mismatch(exp_r, got);
            end
            else
            begin
                exp_r = pending_sorted.pop_front();
                if (directed_sorted.size() != 0)
                begin
                    if (directed_sorted[0] !== exp_r)
                        report_mismatch(directed_sorted[0], exp_r);
                    void'(directed_sorted.pop_front());
                end
                if (got !== exp_r)
                    report_mismatch(exp_r, got);
            end
        end
        if (idle_enable && $urandom_range(0, 4) == 0)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= 1'b1;
    end

    initial
    begin
        #20000000;
        $display("signed_word_sorter_tb: errors");
        $finish;
    end

    initial
    begin
        int   set_len;
        int   sent;
        rst_n = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        s_axis_tvalid = 1'b0;
        m_axis_tready = 1'b0;
        held_ovf = 1'b0;
        mismatches = 0;
        idle_enable = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, single-element sets, equal values and the full store with two dropped words.
        directed_rows.push_back(row(MaxWord, 1'b1));
        directed_sorted.push_back({MaxWord, 1'b1, 1'b0});
        directed_rows.push_back(row(MaxWord, 1'b0));
        directed_rows.push_back(row(64'd0, 1'b0));
        directed_rows.push_back(row(64'hffff_ffff_ffff_ffff, 1'b0));
        directed_rows.push_back(row(MinWord, 1'b0));
        directed_rows.push_back(row(64'd1, 1'b0));
        directed_rows.push_back(row(64'd1, 1'b1));
        directed_sorted.push_back({MinWord, 1'b0, 1'b0});
        directed_sorted.push_back({64'hffff_ffff_ffff_ffff, 1'b0, 1'b0});
        directed_sorted.push_back({64'd0, 1'b0, 1'b0});
        directed_sorted.push_back({64'd1, 1'b0, 1'b0});
        directed_sorted.push_back({64'd1, 1'b0, 1'b0});
        directed_sorted.push_back({MaxWord, 1'b1, 1'b0});
        directed_rows.push_back(row(MinWord, 1'b1));
        directed_sorted.push_back({MinWord, 1'b1, 1'b0});
        foreach (directed_rows[i])
            send_item(directed_rows[i]);
        drain_wait();

        for (int i = 0; i < Capacity; i++)
            send_item(row(DataW'(Capacity - 1 - i), 1'b0));
        send_item(row(MinWord, 1'b0));
        send_item(row(MaxWord, 1'b1));
        drain_wait();

        sent = 0;
        while (sent < 150)
        begin
            if (sent > 120)
                idle_enable = 1'b0;
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 68)
                                                   : $urandom_range(1, 8);
            for (int j = 0; j < set_len; j++)
                send_item(row(random_word(), j == set_len - 1));
            sent += set_len;
            if ($urandom_range(0, 7) == 0)
                drain_wait();
        end
        s_axis_tvalid <= 1'b0;
        while (pending_sorted.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("signed_word_sorter_tb: clean");
        else
            $display("signed_word_sorter_tb: errors");
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/sws_pkg.sv
hdl/signed_word_sorter.sv
dv/signed_word_sorter_tb.sv
